/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define AWMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define AWMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/awmd_pkg.sv */
// Types, constants and the divide step of the alpha weighted mip downsampler.
package awmd_pkg;

    localparam int BYTE_W     = 8;
    localparam int QUAD       = 4;                  // pixels per quad
    localparam int CH         = 3;                  // colour channels
    localparam int ALPHA_LSB  = 24;                 // alpha byte position
    localparam int PROD_W     = 2 * BYTE_W;         // colour * alpha
    localparam int SUM_W      = PROD_W + 2;         // sum of four products
    localparam int NUM_W      = SUM_W + BYTE_W;     // max_colour * sum
    localparam int QUO_W      = BYTE_W;             // quotient never exceeds 255
    localparam int QSEL_W     = $clog2(QUO_W);
    localparam int DIV_STAGES = QUO_W;              // one quotient bit per stage

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [BYTE_W-1:0] byte_t;

    // Item state carried through the divider pipeline
    typedef struct packed {
        logic [CH-1:0][NUM_W-1:0] rem;
        logic [SUM_W-1:0]         den;
        logic [CH-1:0][QUO_W-1:0] quo;
        byte_t                    alpha;
    } awmd_div_t;

    // One restoring division step: resolves quotient bit sh of every channel
    function automatic awmd_div_t div_step(awmd_div_t d, logic [QSEL_W-1:0] sh);
        awmd_div_t        r;
        logic [NUM_W-1:0] trial;
        int unsigned      c;
        r     = d;
        trial = NUM_W'(d.den) << sh;
        for (c = 0; c < CH; c++) begin
            if (d.rem[c] >= trial) begin
                r.rem[c]     = d.rem[c] - trial;
                r.quo[c][sh] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/alpha_weighted_mip_downsample.sv */
// Top level of the alpha weighted 2x2 RGBA8 mip downsampler.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one quad of four RGBA8 pixels
//   per item, bytes packed red, green, blue, alpha from bit 0 upward.
//   Output channel (out_valid/out_ready) gives one reduced RGBA8 pixel per
//   item: alpha is the largest source alpha, each colour channel is
//   max_colour * sum(colour*alpha) / largest channel sum, truncated, and
//   zero when every channel sum is zero.
//   From acceptance to out_valid an item passes three front stages
//   (products, sums and maxima, numerator and divisor) followed by an
//   8-stage restoring divider that settles one quotient bit per stage.
//   Throughput is one item per cycle while the receiver takes results.
//   Every stage has its own valid bit and loads when it is empty or its
//   successor loads, so a stalled receiver holds the result in the output
//   register while bubbles further up keep filling; in_ready drops only once
//   every stage holds an item.
//   Reset clears all valid bits; no result is shown until a new item arrives.
module alpha_weighted_mip_downsample (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pixel_top_left,
    input  logic [31:0] pixel_top_right,
    input  logic [31:0] pixel_bottom_left,
    input  logic [31:0] pixel_bottom_right,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha
);
    import awmd_pkg::*;

    // ---------------------------------------------------------------
    // Stage 1: colour * alpha products, per-pixel colour max and alpha
    // ---------------------------------------------------------------
    logic [QUAD-1:0][31:0]              pix;
    logic [QUAD-1:0][CH-1:0][PROD_W-1:0] prod_next;
    logic [QUAD-1:0][BYTE_W-1:0]        pmax_next;

    logic                                s1_valid_reg;
    logic [QUAD-1:0][CH-1:0][PROD_W-1:0] s1_prod_reg;
    logic [QUAD-1:0][BYTE_W-1:0]         s1_pmax_reg;
    logic [QUAD-1:0][BYTE_W-1:0]         s1_alpha_reg;
    logic                                s1_ready;

    assign pix[0] = pixel_top_left;
    assign pix[1] = pixel_top_right;
    assign pix[2] = pixel_bottom_left;
    assign pix[3] = pixel_bottom_right;

    always_comb
    begin
        byte_t v;
        byte_t a;
        for (int p = 0; p < QUAD; p++) begin
            a            = pix[p][ALPHA_LSB +: BYTE_W];
            pmax_next[p] = '0;
            for (int c = 0; c < CH; c++) begin
                v               = pix[p][c*BYTE_W +: BYTE_W];
                prod_next[p][c] = PROD_W'(v) * PROD_W'(a);
                if (v > pmax_next[p])
                begin
                    pmax_next[p] = v;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: channel sums, quad colour max and alpha max
    // ---------------------------------------------------------------
    logic [CH-1:0][SUM_W-1:0] sum_next;
    byte_t                    colour_next;
    byte_t                    alpha_next;

    logic                     s2_valid_reg;
    logic [CH-1:0][SUM_W-1:0] s2_sum_reg;
    byte_t                    s2_colour_reg;
    byte_t                    s2_alpha_reg;
    logic                     s2_ready;

    always_comb
    begin
        colour_next = '0;
        alpha_next  = '0;
        for (int c = 0; c < CH; c++) begin
            sum_next[c] = '0;
            for (int p = 0; p < QUAD; p++) begin
                sum_next[c] = sum_next[c] + SUM_W'(s1_prod_reg[p][c]);
            end
        end
        for (int p = 0; p < QUAD; p++) begin
            if (s1_pmax_reg[p] > colour_next)
            begin
                colour_next = s1_pmax_reg[p];
            end
            if (s1_alpha_reg[p] > alpha_next)
            begin
                alpha_next = s1_alpha_reg[p];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: numerators and divisor for the divider
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] top_sum;
    awmd_div_t        div_next;

    logic             s3_valid_reg;
    awmd_div_t        s3_div_reg;
    logic             s3_ready;
    logic             div_in_ready;

    always_comb
    begin
        top_sum = s2_sum_reg[CH_RED];
        if (s2_sum_reg[CH_GREEN] > top_sum)
        begin
            top_sum = s2_sum_reg[CH_GREEN];
        end
        if (s2_sum_reg[CH_BLUE] > top_sum)
        begin
            top_sum = s2_sum_reg[CH_BLUE];
        end
        for (int c = 0; c < CH; c++) begin
            div_next.rem[c] = NUM_W'(s2_colour_reg) * NUM_W'(s2_sum_reg[c]);
        end
        // all sums zero: numerators are zero too, so a divisor of one gives zeros
        div_next.den   = (top_sum == '0) ? SUM_W'(1) : top_sum;
        div_next.quo   = '0;
        div_next.alpha = s2_alpha_reg;
    end

    // ---------------------------------------------------------------
    // Handshake chain: a stage loads when empty or when its successor loads
    // ---------------------------------------------------------------
    assign s3_ready = !s3_valid_reg || div_in_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_prod_reg <= prod_next;
            s1_pmax_reg <= pmax_next;
            for (int p = 0; p < QUAD; p++) begin
                s1_alpha_reg[p] <= pix[p][ALPHA_LSB +: BYTE_W];
            end
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sum_reg    <= sum_next;
            s2_colour_reg <= colour_next;
            s2_alpha_reg  <= alpha_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_div_reg <= div_next;
        end
    end

    // ---------------------------------------------------------------
    // Divider pipeline; its last stage is the output register
    // ---------------------------------------------------------------
    awmd_div_t div_out;

    awmd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_data   (s3_div_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (div_out)
    );

    assign out_red   = div_out.quo[CH_RED];
    assign out_green = div_out.quo[CH_GREEN];
    assign out_blue  = div_out.quo[CH_BLUE];
    assign out_alpha = div_out.alpha;

endmodule

/* rtl/awmd_divider.sv */
// Pipelined restoring divider: one quotient bit per stage, three channels.
module awmd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  awmd_pkg::awmd_div_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output awmd_pkg::awmd_div_t out_data
);
    import awmd_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    awmd_div_t             data_reg [DIV_STAGES];
    logic [DIV_STAGES:0]   valid_chain;
    awmd_div_t             data_chain [DIV_STAGES+1];
    logic [DIV_STAGES:0]   ready_chain;

    assign valid_chain[0]          = in_valid;
    assign data_chain[0]           = in_data;
    assign ready_chain[DIV_STAGES] = out_ready;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        awmd_div_t step_next;

        assign valid_chain[k+1] = valid_reg[k];
        assign data_chain[k+1]  = data_reg[k];
        assign ready_chain[k]   = !valid_reg[k] || ready_chain[k+1];
        // MSB first
        assign step_next = div_step(data_chain[k], QSEL_W'(QUO_W - 1 - k));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ready_chain[k])
            begin
                valid_reg[k] <= valid_chain[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready_chain[k] && valid_chain[k])
            begin
                data_reg[k] <= step_next;
            end
        end
    end

    assign in_ready  = ready_chain[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_data  = data_reg[DIV_STAGES-1];

endmodule

/* rtl/awmd_checker.sv */
// Port-level checker for the alpha weighted mip downsampler, with its bind.
`include "assert_macros.svh"

module awmd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] pixel_top_left,
    input logic [31:0] pixel_top_right,
    input logic [31:0] pixel_bottom_left,
    input logic [31:0] pixel_bottom_right,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_red,
    input logic [7:0]  out_green,
    input logic [7:0]  out_blue,
    input logic [7:0]  out_alpha
);

    // no result is offered while reset holds
    `AWMD_ASSERT_ALWAYS(a_no_out_in_reset, clk, (!rst_n |-> !out_valid), "out_valid during reset")

    // a stalled result stays put
    `AWMD_ASSERT(a_out_hold, clk, rst_n, ((out_valid && !out_ready) |=> (out_valid && $stable({out_red, out_green, out_blue, out_alpha}))), "stalled result changed")

    // fully transparent quad has no colour
    `AWMD_ASSERT(a_clear_black, clk, rst_n, ((out_valid && out_alpha == 8'd0) |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)), "colour on zero alpha")

    // an open receiver never back-pressures the source
    `AWMD_ASSERT(a_ready_flow, clk, rst_n, (out_ready |-> in_ready), "in_ready low with out_ready high")

endmodule

bind alpha_weighted_mip_downsample awmd_checker u_awmd_checker (.*);
